// File: sv/sqlx_pkg.sv
// Shared types and constants for the SQL tuple field extractor.
`default_nettype none

package sqlx_pkg;

   localparam int BYTE_W     = 8;
   localparam int LINES_W    = 16;
   localparam int FIELD_W    = 3;
   localparam int FCOUNT_W   = 4;
   localparam int MODE_W     = 3;
   localparam int CSR_IDX_W  = 2;

   // parse modes
   localparam logic [MODE_W-1:0] MODE_HEADER = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SEEK   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIELD  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STRING = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ESCAPE = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SKIP   = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_LINES     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SELECTED_FIELD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELDS_PER_TUPLE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TUPLE_LIMIT      = 2'd3;

   // characters
   localparam logic [BYTE_W-1:0] CHR_NEWLINE   = 8'h0A;
   localparam logic [BYTE_W-1:0] CHR_QUOTE     = 8'h27;
   localparam logic [BYTE_W-1:0] CHR_LPAREN    = 8'h28;
   localparam logic [BYTE_W-1:0] CHR_RPAREN    = 8'h29;
   localparam logic [BYTE_W-1:0] CHR_COMMA     = 8'h2C;
   localparam logic [BYTE_W-1:0] CHR_BACKSLASH = 8'h5C;

   // register reset values
   localparam logic [LINES_W-1:0]  HEADER_LINES_RST     = 16'd42 + 16'd1;
   localparam logic [FIELD_W-1:0]  SELECTED_FIELD_RST   = 3'd2;
   localparam logic [FCOUNT_W-1:0] FIELDS_PER_TUPLE_RST = 4'd6;
   localparam longint unsigned     TUPLE_LIMIT_RST      = 40000000;
   localparam logic [FCOUNT_W-1:0] FIELDS_MAX           = 4'd8;

   typedef struct packed {
      logic [LINES_W-1:0]  header_lines;
      logic [FIELD_W-1:0]  selected_field;
      logic [FCOUNT_W-1:0] fields_per_tuple;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [LINES_W-1:0] lines_skipped;
      logic [FIELD_W-1:0] field_index;
   } parse_state_type;

   typedef struct packed {
      logic              text_valid;
      logic [BYTE_W-1:0] text_byte;
   } text_type;

endpackage

`default_nettype wire

// File: sv/sqlx_if.sv
// Valid/ready channel interfaces for the request and response streams.
`default_nettype none

interface sqlx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface sqlx_rsp_if #(
   parameter int COUNT_WIDTH = 26
);
   logic                   valid;
   logic                   ready;
   logic                   text_valid;
   logic [7:0]             text_byte;
   logic                   done_res;
   logic [COUNT_WIDTH-1:0] tuple_count;

   modport source (output valid, output text_valid, output text_byte, output done_res,
                   output tuple_count, input ready);
   modport sink   (input valid, input text_valid, input text_byte, input done_res,
                   input tuple_count, output ready);
endinterface

`default_nettype wire

// File: sv/sqlx_step.sv
// Per-byte parser step: next parse state, tuple count and extracted text.
`default_nettype none

module sqlx_step #(
   parameter int COUNT_WIDTH = 26
) (
   input  sqlx_pkg::cfg_type         cfg,
   input  wire [COUNT_WIDTH-1:0]     tuple_limit,
   input  sqlx_pkg::parse_state_type st,
   input  wire [COUNT_WIDTH-1:0]     tuples_seen,
   input  wire [7:0]                 in_byte,
   input  wire                       end_of_stream,
   output sqlx_pkg::parse_state_type st_next,
   output logic [COUNT_WIDTH-1:0]    tuples_next,
   output sqlx_pkg::text_type        text
);
   import sqlx_pkg::*;

   logic [MODE_W-1:0]   mode;
   logic [FCOUNT_W-1:0] field_total;
   logic [FCOUNT_W-1:0] field_inc;
   logic                sel;

   always_comb begin
      if (cfg.fields_per_tuple == '0) begin
         field_total = FCOUNT_W'(1);
      end else if (cfg.fields_per_tuple > FIELDS_MAX) begin
         field_total = FIELDS_MAX;
      end else begin
         field_total = cfg.fields_per_tuple;
      end
   end

   assign field_inc = {1'b0, st.field_index} + FCOUNT_W'(1);
   assign sel       = (st.field_index == cfg.selected_field);

   always_comb begin
      st_next     = st;
      tuples_next = tuples_seen;
      text        = '0;
      mode        = st.mode;
      if (!end_of_stream) begin
         // header already satisfied: this byte is handled as tuple search
         if (mode == MODE_HEADER && st.lines_skipped >= cfg.header_lines) begin
            mode = MODE_SEEK;
         end
         unique case (mode)
            MODE_HEADER: begin
               if (in_byte == CHR_NEWLINE) begin
                  st_next.lines_skipped = st.lines_skipped + LINES_W'(1);
                  if (st.lines_skipped + LINES_W'(1) >= cfg.header_lines) begin
                     mode = MODE_SEEK;
                  end
               end
            end
            MODE_SEEK: begin
               if (in_byte == CHR_LPAREN && tuples_seen < tuple_limit) begin
                  tuples_next         = tuples_seen + COUNT_WIDTH'(1);
                  st_next.field_index = '0;
                  mode                = MODE_FIELD;
               end
            end
            MODE_FIELD: begin
               if (in_byte == CHR_COMMA) begin
                  if (sel) begin
                     text.text_valid = 1'b1;
                     text.text_byte  = CHR_NEWLINE;
                  end
                  if (field_inc >= field_total) begin
                     st_next.field_index = '0;
                     mode                = MODE_SKIP;
                  end else begin
                     st_next.field_index = field_inc[FIELD_W-1:0];
                  end
               end else if (in_byte == CHR_QUOTE) begin
                  mode = MODE_STRING;
               end else if (sel) begin
                  text.text_valid = 1'b1;
                  text.text_byte  = in_byte;
               end
            end
            MODE_STRING: begin
               if (in_byte == CHR_QUOTE) begin
                  mode = MODE_FIELD;
               end else begin
                  if (in_byte == CHR_BACKSLASH) begin
                     mode = MODE_ESCAPE;
                  end
                  if (sel) begin
                     text.text_valid = 1'b1;
                     text.text_byte  = in_byte;
                  end
               end
            end
            MODE_ESCAPE: begin
               if (sel) begin
                  text.text_valid = 1'b1;
                  text.text_byte  = in_byte;
               end
               mode = MODE_STRING;
            end
            MODE_SKIP: begin
               if (in_byte == CHR_RPAREN) begin
                  mode = MODE_SEEK;
               end
            end
            default: begin
               mode = MODE_SEEK;
            end
         endcase
         st_next.mode = mode;
      end
   end

endmodule

`default_nettype wire

// File: sv/sql_tuple_field_extractor.sv
// Top level: SQL dump tuple field extractor with config registers and result register.
//
//   channel   dir   handshake            beat contents
//   req_ch    in    valid/ready          in_byte, end_of_stream
//   rsp_ch    out   valid/ready          text_valid, text_byte, done_res, tuple_count
//   csr_*     in    csr_wr_en (no wait)  csr_index, csr_wr_data
//
// One beat in, one beat out; a byte is taken every cycle while rsp_ch is not stalled, and each response is registered.
// The parser step is one combinational pass into the response register.
// A new request beat is taken while rsp_ch is empty or being drained, so a
// stall on rsp_ch holds req_ch.ready low only while the result is pending.
// Reset (synchronous) returns registers to defaults and the parser to header skip.
`default_nettype none

module sql_tuple_field_extractor #(
   parameter int COUNT_WIDTH = 26
) (
   input  wire                                      clock,
   input  wire                                      reset,
   sqlx_req_if.sink                                 req_ch,
   sqlx_rsp_if.source                               rsp_ch,
   input  wire                                      csr_wr_en,
   input  wire [sqlx_pkg::CSR_IDX_W-1:0]            csr_index,
   input  wire [((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16)-1:0] csr_wr_data
);
   import sqlx_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] LIMIT_RST = COUNT_WIDTH'(TUPLE_LIMIT_RST);

   cfg_type                cfg_ff;
   logic [COUNT_WIDTH-1:0] tuple_limit_ff;

   parse_state_type        st_ff, st_in;
   logic [COUNT_WIDTH-1:0] tuples_ff, tuples_in;
   text_type               text_in;

   logic                   rsp_valid_ff;
   text_type               text_ff;
   logic                   done_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic                   accept;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_lines     <= HEADER_LINES_RST;
         cfg_ff.selected_field   <= SELECTED_FIELD_RST;
         cfg_ff.fields_per_tuple <= FIELDS_PER_TUPLE_RST;
         tuple_limit_ff          <= LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HEADER_LINES:     cfg_ff.header_lines     <= csr_wr_data[LINES_W-1:0];
            CSR_SELECTED_FIELD:   cfg_ff.selected_field   <= csr_wr_data[FIELD_W-1:0];
            CSR_FIELDS_PER_TUPLE: cfg_ff.fields_per_tuple <= csr_wr_data[FCOUNT_W-1:0];
            CSR_TUPLE_LIMIT:      tuple_limit_ff          <= csr_wr_data[COUNT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   sqlx_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .cfg           (cfg_ff),
      .tuple_limit   (tuple_limit_ff),
      .st            (st_ff),
      .tuples_seen   (tuples_ff),
      .in_byte       (req_ch.in_byte),
      .end_of_stream (req_ch.end_of_stream),
      .st_next       (st_in),
      .tuples_next   (tuples_in),
      .text          (text_in)
   );

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode          <= MODE_HEADER;
         st_ff.lines_skipped <= '0;
         st_ff.field_index   <= '0;
         tuples_ff           <= '0;
      end else if (accept) begin
         st_ff     <= st_in;
         tuples_ff <= tuples_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         text_ff  <= text_in;
         done_ff  <= req_ch.end_of_stream;
         count_ff <= tuples_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.text_valid  = text_ff.text_valid;
   assign rsp_ch.text_byte   = text_ff.text_byte;
   assign rsp_ch.done_res    = done_ff;
   assign rsp_ch.tuple_count = count_ff;

   // the tuple count only ever steps by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && tuples_ff != $past(tuples_ff))
         |-> (tuples_ff == $past(tuples_ff) + COUNT_WIDTH'(1)))
      else $error("tuple count jumped");

   // parser state moves only on an accepted beat
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(accept)) |-> ($stable(st_ff) && $stable(tuples_ff)))
      else $error("parser state changed without a request beat");

   // end-of-stream beat carries no text
   a_done_no_text: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> !text_ff.text_valid)
      else $error("text on end-of-stream beat");

   // idle text byte reads as zero
   a_text_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !text_ff.text_valid) |-> (text_ff.text_byte == '0))
      else $error("text_byte nonzero without text_valid");

endmodule

`default_nettype wire

// File: dv/sql_tuple_field_extractor_tb.sv
// Self-checking testbench for the SQL tuple field extractor: dump streams in, field text checked.
`timescale 1ns / 100ps

module sql_tuple_field_extractor_tb;
   import sqlx_pkg::*;

   localparam int CNT_W = 26;
   localparam int CSR_W = (CNT_W > 16) ? CNT_W : 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 150;
   localparam logic [CNT_W-1:0] LIMIT_MAX = {CNT_W{1'b1}};

   typedef struct packed {
      text_type         text;
      logic             done_res;
      logic [CNT_W-1:0] tuple_count;
   } extract_beat;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              eos;
   } dump_beat;

   class extract_scoreboard;
      cfg_type          cfg;
      logic [CNT_W-1:0] tuple_limit;
      parse_state_type  st;
      logic [CNT_W-1:0] tuples;
      extract_beat      expected_q[$];
      int               failures;

      function new();
         cfg.header_lines     = HEADER_LINES_RST;
         cfg.selected_field   = SELECTED_FIELD_RST;
         cfg.fields_per_tuple = FIELDS_PER_TUPLE_RST;
         tuple_limit          = CNT_W'(TUPLE_LIMIT_RST);
         st.mode              = MODE_HEADER;
         st.lines_skipped     = '0;
         st.field_index       = '0;
         tuples               = '0;
         failures             = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_HEADER_LINES:     cfg.header_lines = data[LINES_W-1:0];
            CSR_SELECTED_FIELD:   cfg.selected_field = data[FIELD_W-1:0];
            CSR_FIELDS_PER_TUPLE: cfg.fields_per_tuple = data[FCOUNT_W-1:0];
            CSR_TUPLE_LIMIT:      tuple_limit = data[CNT_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // advance the parser by one byte and queue the text it produces
      function void note_byte(logic [BYTE_W-1:0] b, logic eos);
         extract_beat       e;
         logic              sel;
         logic [MODE_W-1:0] mode;
         int                total;
         e = '0;
         sel = (st.field_index == cfg.selected_field);
         if (cfg.fields_per_tuple == 0) total = 1;
         else if (cfg.fields_per_tuple > FIELDS_MAX) total = int'(FIELDS_MAX);
         else total = int'(cfg.fields_per_tuple);
         if (!eos) begin
            mode = st.mode;
            if (mode == MODE_HEADER && st.lines_skipped >= cfg.header_lines) mode = MODE_SEEK;
            case (mode)
               MODE_HEADER: begin
                  if (b == CHR_NEWLINE) begin
                     st.lines_skipped = st.lines_skipped + 1'b1;
                     if (st.lines_skipped >= cfg.header_lines) mode = MODE_SEEK;
                  end
               end
               MODE_SEEK: begin
                  if (b == CHR_LPAREN && tuples < tuple_limit) begin
                     tuples = tuples + 1'b1;
                     st.field_index = '0;
                     mode = MODE_FIELD;
                  end
               end
               MODE_FIELD: begin
                  if (b == CHR_COMMA) begin
                     if (sel) e.text = '{1'b1, CHR_NEWLINE};
                     if (int'(st.field_index) + 1 >= total) begin
                        st.field_index = '0;
                        mode = MODE_SKIP;
                     end else begin
                        st.field_index = st.field_index + 1'b1;
                     end
                  end else if (b == CHR_QUOTE) begin
                     mode = MODE_STRING;
                  end else if (sel) begin
                     e.text = '{1'b1, b};
                  end
               end
               MODE_STRING: begin
                  if (b == CHR_QUOTE) begin
                     mode = MODE_FIELD;
                  end else begin
                     if (b == CHR_BACKSLASH) mode = MODE_ESCAPE;
                     if (sel) e.text = '{1'b1, b};
                  end
               end
               MODE_ESCAPE: begin
                  if (sel) e.text = '{1'b1, b};
                  mode = MODE_STRING;
               end
               MODE_SKIP: begin
                  if (b == CHR_RPAREN) mode = MODE_SEEK;
               end
               default: mode = MODE_SEEK;
            endcase
            st.mode = mode;
         end
         e.done_res = eos;
         e.tuple_count = tuples;
         expected_q.push_back(e);
      endfunction

      function void check_out(logic tv, logic [BYTE_W-1:0] tb, logic dr, logic [CNT_W-1:0] tc);
         extract_beat e;
         if (expected_q.size() == 0) begin
            $error("unexpected rsp beat: text_valid %0d text_byte 0x%02h done_res %0d count %0d",
                   tv, tb, dr, tc);
            failures++;
            return;
         end
         e = expected_q.pop_front();
         if (tv !== e.text.text_valid) begin
            $error("text_valid: expected %0d, got %0d", e.text.text_valid, tv);
            failures++;
         end
         if (tb !== e.text.text_byte) begin
            $error("text_byte: expected 0x%02h, got 0x%02h", e.text.text_byte, tb);
            failures++;
         end
         if (dr !== e.done_res) begin
            $error("done_res: expected %0d, got %0d", e.done_res, dr);
            failures++;
         end
         if (tc !== e.tuple_count) begin
            $error("tuple_count: expected %0d, got %0d", e.tuple_count, tc);
            failures++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wr_data;
   logic                 idle_enable;
   // a toggle on hold_req asks the response side for one long hold-off
   logic                 hold_req = 1'b0;
   logic                 hold_seen;
   int                   hold_left = 0;
   int                   cycle_count = 0;

   dump_beat          dump_q[$];
   extract_scoreboard sb;

   sqlx_req_if                          req_ch ();
   sqlx_rsp_if #(.COUNT_WIDTH(CNT_W))   rsp_ch ();

   sql_tuple_field_extractor #(.COUNT_WIDTH(CNT_W)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // response side: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= hold_req;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_left <= HOLD_CYCLES;
         hold_seen <= hold_req;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !(idle_enable && $urandom_range(0, 99) < 12);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_out(rsp_ch.text_valid, rsp_ch.text_byte, rsp_ch.done_res,
                         rsp_ch.tuple_count);
         if (req_ch.valid && req_ch.ready)
            sb.note_byte(req_ch.in_byte, req_ch.end_of_stream);
      end
   end

   function void put(logic [BYTE_W-1:0] b);
      dump_beat x;
      x.in_byte = b;
      x.eos = 1'b0;
      dump_q.push_back(x);
   endfunction

   function void put_eos();
      dump_beat x;
      x.in_byte = BYTE_W'($urandom_range(0, 255));
      x.eos = 1'b1;
      dump_q.push_back(x);
   endfunction

   // unquoted field text: never a comma or a quote
   function logic [BYTE_W-1:0] field_char();
      logic [BYTE_W-1:0] c;
      case ($urandom_range(0, 9))
         0:       c = CHR_RPAREN;
         1:       c = CHR_LPAREN;
         2, 3:    c = BYTE_W'($urandom_range(0, 255));
         default: c = BYTE_W'($urandom_range(8'h61, 8'h7a));
      endcase
      if (c == CHR_COMMA || c == CHR_QUOTE) c = 8'h2E;
      return c;
   endfunction

   function void put_string();
      logic [BYTE_W-1:0] c;
      put(CHR_QUOTE);
      repeat ($urandom_range(0, 5)) begin
         case ($urandom_range(0, 5))
            0: begin
               put(CHR_BACKSLASH);
               put(BYTE_W'($urandom_range(0, 255)));
            end
            1: put(CHR_COMMA);
            2: begin
               c = BYTE_W'($urandom_range(0, 255));
               if (c == CHR_QUOTE || c == CHR_BACKSLASH) c = CHR_RPAREN;
               put(c);
            end
            default: put(BYTE_W'($urandom_range(8'h61, 8'h7a)));
         endcase
      end
      put(CHR_QUOTE);
   endfunction

   function void put_tuple(int nfields);
      put(CHR_LPAREN);
      for (int i = 0; i < nfields; i++) begin
         repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 4) == 0) put_string();
            else put(field_char());
         end
         put(CHR_COMMA);
      end
      repeat ($urandom_range(0, 3)) put(BYTE_W'($urandom_range(8'h30, 8'h39)));
      put(CHR_RPAREN);
      put($urandom_range(0, 1) ? CHR_COMMA : CHR_NEWLINE);
   endfunction

   // mostly well-formed tuples, some noise, cut-off tuples and end markers
   function void build_dump(int target, int nfields);
      int n;
      while (dump_q.size() < target) begin
         case ($urandom_range(0, 19))
            0: repeat ($urandom_range(1, 6)) put(BYTE_W'($urandom_range(0, 255)));
            1: begin
               put(CHR_LPAREN);
               repeat ($urandom_range(0, 4)) put(field_char());
               repeat ($urandom_range(1, 4)) put(BYTE_W'($urandom_range(0, 255)));
            end
            2: put_eos();
            default: begin
               n = nfields;
               if ($urandom_range(0, 7) == 0) n = nfields + 1;
               else if ($urandom_range(0, 7) == 0 && nfields > 1) n = nfields - 1;
               put_tuple(n);
            end
         endcase
      end
   endfunction

   task automatic send_beat(logic [BYTE_W-1:0] b, logic eos);
      if (idle_enable && $urandom_range(0, 99) < 12) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.end_of_stream <= eos;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_dump();
      dump_beat x;
      while (dump_q.size() > 0) begin
         x = dump_q.pop_front();
         send_beat(x.in_byte, x.eos);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(int hdr, int sel, int nfields, logic [CNT_W-1:0] lim,
                            int target, bit idle, bit hold);
      drain();
      write_reg(CSR_HEADER_LINES, CSR_W'(hdr));
      write_reg(CSR_SELECTED_FIELD, CSR_W'(sel));
      write_reg(CSR_FIELDS_PER_TUPLE, CSR_W'(nfields));
      write_reg(CSR_TUPLE_LIMIT, CSR_W'(lim));
      idle_enable <= idle;
      if (hold) hold_req <= !hold_req;
      build_dump(target, nfields);
      send_dump();
   endtask

   initial begin
      int nf;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.in_byte = '0;
      req_ch.end_of_stream = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      idle_enable = 1'b1;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // header mode under reset registers: parens ignored, two lines counted
      put(8'h68); put(CHR_LPAREN); put(CHR_NEWLINE); put(8'hFF);
      put(CHR_NEWLINE); put_eos(); put(8'h00);
      send_dump();
      drain();
      // header count already met, so the next byte goes straight to tuple search
      write_reg(CSR_HEADER_LINES, CSR_W'(2));
      write_reg(CSR_SELECTED_FIELD, CSR_W'(0));
      write_reg(CSR_FIELDS_PER_TUPLE, CSR_W'(2));
      put(CHR_LPAREN); put(CHR_QUOTE); put(8'h61); put(CHR_BACKSLASH); put(CHR_QUOTE);
      put(CHR_RPAREN); put(CHR_QUOTE); put(8'h62); put(CHR_RPAREN); put(CHR_COMMA);
      put(8'h78); put(CHR_COMMA); put(8'h79); put(CHR_RPAREN); put_eos();
      put(CHR_LPAREN); put(CHR_BACKSLASH); put(CHR_COMMA);
      send_dump();

      run_phase(0, 7, 8, LIMIT_MAX, 80, 1, 0);
      run_phase(65535, 0, 1, LIMIT_MAX, 80, 1, 1);
      // selected field beyond the field count: no text at all
      run_phase($urandom_range(0, 65535), 7, 1, LIMIT_MAX, 60, 1, 0);
      drain();
      nf = $urandom_range(1, 8);
      run_phase($urandom_range(0, 65535), $urandom_range(0, nf - 1), nf,
                CNT_W'(sb.tuples + 2), 80, 1, 0);
      run_phase($urandom_range(0, 65535), 0, 3, 1, 60, 1, 0);
      nf = $urandom_range(1, 8);
      run_phase($urandom_range(0, 65535), $urandom_range(0, nf - 1), nf,
                LIMIT_MAX, 100, 0, 0);
      nf = $urandom_range(1, 8);
      run_phase($urandom_range(0, 65535), $urandom_range(0, nf - 1), nf,
                LIMIT_MAX, 90, 1, 1);
      nf = $urandom_range(1, 8);
      run_phase($urandom_range(0, 65535), $urandom_range(0, 7), nf,
                CNT_W'($urandom_range(sb.tuples + 5, 32'h3FFFFFF)), 90, 1, 0);

      drain();
      repeat (4) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
